>>> rtl/core/drv_pkg.sv
package drv_pkg;

  // Result codes, in the order the checks are applied.
  typedef enum logic [2:0] {
    FAIL_OK        = 3'd0,
    FAIL_YEAR_GAP  = 3'd1,
    FAIL_BAD_MONTH = 3'd2,
    FAIL_BAD_DAY   = 3'd3,
    FAIL_ORDER     = 3'd4,
    FAIL_SPAN      = 3'd5
  } fail_code_t;

  // Check outcomes that ride along the pipeline with each word.
  typedef struct packed {
    logic year_gap;
    logic month_bad;
    logic ordered;
    logic same_year;
  } chk_flags_t;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned SPAN_W  = 10;
  localparam int unsigned LIMIT_W = 9;

  // Division by 25 as a multiply by a rounded-up reciprocal and a shift.
  // Exact for every 14-bit year.
  localparam int unsigned DIV25_SHIFT = 19;
  localparam int unsigned DIV25_RECIP = ((1 << DIV25_SHIFT) + 24) / 25;
  localparam int unsigned PROD_W      = YEAR_W + 15;
  localparam int unsigned QUOT_W      = PROD_W - DIV25_SHIFT;

  localparam logic [SPAN_W-1:0]  DAYS_IN_YEAR = SPAN_W'(365);
  localparam logic [LIMIT_W-1:0] TERM_RESET   = LIMIT_W'(30);
  localparam logic [MONTH_W-1:0] MONTH_FEB    = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC    = MONTH_W'(12);

  // Days before the first of a month (months 1..12); other codes read as zero.
  function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    begin
      unique case (m)
        4'd1:    r = DOY_W'(0);
        4'd2:    r = DOY_W'(31);
        4'd3:    r = DOY_W'(59);
        4'd4:    r = DOY_W'(90);
        4'd5:    r = DOY_W'(120);
        4'd6:    r = DOY_W'(151);
        4'd7:    r = DOY_W'(181);
        4'd8:    r = DOY_W'(212);
        4'd9:    r = DOY_W'(243);
        4'd10:   r = DOY_W'(273);
        4'd11:   r = DOY_W'(304);
        4'd12:   r = DOY_W'(334);
        default: r = DOY_W'(0);
      endcase
      return r;
    end
  endfunction

  // Length of a month, with February following the leap flag.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    begin
      unique case (m)
        4'd4, 4'd6, 4'd9, 4'd11: r = DAY_W'(30);
        4'd2:                    r = leap ? DAY_W'(29) : DAY_W'(28);
        default:                 r = DAY_W'(31);
      endcase
      return r;
    end
  endfunction

endpackage

>>> rtl/core/date_range_validator.sv
// A word taken with start passes through four register stages, A, B, C and the
// result register, before its result shows with done high.
// Throughput: one word per cycle; busy is always low and never holds start off.
// Each stage carries a valid bit; done is a single-cycle strobe with no stall.
// Reset (rst, synchronous) clears all valid bits and sets term_limit_days to 30.
module date_range_validator (
  input  logic        clk,
  input  logic        rst,
  // Command channel.
  input  logic        start,
  output logic        busy,
  input  logic [13:0] start_year,
  input  logic [3:0]  start_month,
  input  logic [4:0]  start_day,
  input  logic [4:0]  start_hour,
  input  logic [5:0]  start_minute,
  input  logic [13:0] end_year,
  input  logic [3:0]  end_month,
  input  logic [4:0]  end_day,
  input  logic [4:0]  end_hour,
  input  logic [5:0]  end_minute,
  // Result channel.
  output logic        done,
  output logic        range_ok,
  output logic [2:0]  fail_code,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned YW = drv_pkg::YEAR_W;
  localparam int unsigned MW = drv_pkg::MONTH_W;
  localparam int unsigned DW = drv_pkg::DAY_W;
  localparam int unsigned PW = drv_pkg::PROD_W;
  localparam int unsigned QW = drv_pkg::QUOT_W;
  localparam int unsigned OW = drv_pkg::DOY_W;
  localparam int unsigned SW = drv_pkg::SPAN_W;
  localparam int unsigned LW = drv_pkg::LIMIT_W;

  // Configuration register.
  logic [LW-1:0] term_limit_days;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign busy      = 1'b0;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? 32'(term_limit_days) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_limit_days <= drv_pkg::TERM_RESET;
    end else if (cfg_write) begin
      term_limit_days <= pwdata[LW-1:0];
    end
  end

  // Stage A: year gap, month range, ordering, same year, and the reciprocal products.
  logic [33:0]          skey, ekey;
  drv_pkg::chk_flags_t  a_flags_next;
  logic                 a_valid;
  drv_pkg::chk_flags_t  a_flags;
  logic [YW-1:0]        a_sy, a_ey;
  logic [PW-1:0]        a_sprod, a_eprod;
  logic [MW-1:0]        a_sm, a_em;
  logic [DW-1:0]        a_sd, a_ed;

  assign skey = {start_year, start_month, start_day, start_hour, start_minute};
  assign ekey = {end_year, end_month, end_day, end_hour, end_minute};

  always_comb begin
    a_flags_next.year_gap  = {1'b0, end_year} > ({1'b0, start_year} + 15'd1);
    a_flags_next.month_bad = (start_month == '0) || (start_month > drv_pkg::MONTH_DEC) ||
                             (end_month == '0) || (end_month > drv_pkg::MONTH_DEC);
    a_flags_next.ordered   = skey < ekey;
    a_flags_next.same_year = start_year == end_year;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_flags <= a_flags_next;
    a_sy    <= start_year;
    a_ey    <= end_year;
    a_sprod <= PW'(start_year) * PW'(drv_pkg::DIV25_RECIP);
    a_eprod <= PW'(end_year) * PW'(drv_pkg::DIV25_RECIP);
    a_sm    <= start_month;
    a_em    <= end_month;
    a_sd    <= start_day;
    a_ed    <= end_day;
  end

  // Stage B: divisibility by 25 gives the Gregorian leap flags.
  logic [QW-1:0] sq, eq;
  logic [YW-1:0] sq25, eq25;
  logic          s_div25, e_div25;
  logic          b_valid;
  drv_pkg::chk_flags_t b_flags;
  logic          b_sleap, b_eleap;
  logic [MW-1:0] b_sm, b_em;
  logic [DW-1:0] b_sd, b_ed;

  assign sq      = a_sprod[PW-1:drv_pkg::DIV25_SHIFT];
  assign eq      = a_eprod[PW-1:drv_pkg::DIV25_SHIFT];
  assign sq25    = (YW'(sq) << 4) + (YW'(sq) << 3) + YW'(sq);
  assign eq25    = (YW'(eq) << 4) + (YW'(eq) << 3) + YW'(eq);
  assign s_div25 = sq25 == a_sy;
  assign e_div25 = eq25 == a_ey;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  // Leap when divisible by 4 but not 100, or divisible by 400.
  always_ff @(posedge clk) begin
    b_flags <= a_flags;
    b_sleap <= (a_sy[1:0] == 2'b00 && !s_div25) || (a_sy[3:0] == 4'b0000 && s_div25);
    b_eleap <= (a_ey[1:0] == 2'b00 && !e_div25) || (a_ey[3:0] == 4'b0000 && e_div25);
    b_sm    <= a_sm;
    b_em    <= a_em;
    b_sd    <= a_sd;
    b_ed    <= a_ed;
  end

  // Stage C: day range and day-of-year for both dates.
  logic [DW-1:0] s_len, e_len;
  logic          c_valid;
  drv_pkg::chk_flags_t c_flags;
  logic          c_day_bad;
  logic [OW-1:0] c_sdoy, c_edoy;

  assign s_len = drv_pkg::month_days(b_sm, b_sleap);
  assign e_len = drv_pkg::month_days(b_em, b_eleap);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_flags   <= b_flags;
    c_day_bad <= (b_sd == '0) || (b_sd > s_len) || (b_ed == '0) || (b_ed > e_len);
    c_sdoy    <= drv_pkg::month_offset(b_sm) + OW'(b_sd) +
                 OW'((b_sm > drv_pkg::MONTH_FEB) && b_sleap);
    c_edoy    <= drv_pkg::month_offset(b_em) + OW'(b_ed) +
                 OW'((b_em > drv_pkg::MONTH_FEB) && b_eleap);
  end

  // Stage D: span against the limit, then the first failing check wins.
  logic [SW-1:0]        span;
  drv_pkg::fail_code_t  code_next;

  always_comb begin
    if (c_flags.same_year) begin
      span = SW'(c_edoy) - SW'(c_sdoy);
    end else begin
      span = drv_pkg::DAYS_IN_YEAR - SW'(c_sdoy) + SW'(c_edoy);
    end
  end

  always_comb begin
    priority if (c_flags.year_gap) begin
      code_next = drv_pkg::FAIL_YEAR_GAP;
    end else if (c_flags.month_bad) begin
      code_next = drv_pkg::FAIL_BAD_MONTH;
    end else if (c_day_bad) begin
      code_next = drv_pkg::FAIL_BAD_DAY;
    end else if (!c_flags.ordered) begin
      code_next = drv_pkg::FAIL_ORDER;
    end else if (span > SW'(term_limit_days)) begin
      code_next = drv_pkg::FAIL_SPAN;
    end else begin
      code_next = drv_pkg::FAIL_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    range_ok  <= code_next == drv_pkg::FAIL_OK;
    fail_code <= code_next;
  end

`ifndef SYNTH
  // Every accepted word yields a result strobe.
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted word produced no result");

  // No strobe without an earlier accepted word.
  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##4 !done)
    else $error("result strobe without an accepted word");

  // The pass flag and the code agree.
  a_ok_matches_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (range_ok == (fail_code == drv_pkg::FAIL_OK)))
    else $error("range_ok disagrees with fail_code");

  // Codes stay within the defined set.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (fail_code <= drv_pkg::FAIL_SPAN))
    else $error("undefined fail code");

  // A register write lands on the next edge.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (term_limit_days == $past(pwdata[LW-1:0])))
    else $error("term limit write lost");
`endif

endmodule
